// ===== hw/rtl/bvr_pkg.sv =====
// shared types, codes and helpers for the bit vector rank block
package bvr_pkg;

  localparam int unsigned POS_W      = 13;
  localparam int unsigned COUNT_W    = 13;
  localparam int unsigned WORD_SHIFT = 5;
  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned WIDX_W     = POS_W - WORD_SHIFT;
  localparam int unsigned POP_W      = 6;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_BUILD = 2'd1,
    ACT_RANK  = 2'd2,
    ACT_READ  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_BUILT = 2'd1,
    STAT_RANGE     = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_RANK,
    ST_SCAN,
    ST_DRAIN
  } ctl_state_e;

  typedef struct packed {
    logic load;
    logic clr_wr;
    logic scan_rd;
    logic access;
    logic rank_fin;
    logic build_fin;
  } ctl_cmd_t;

  typedef struct packed {
    logic idx_last;
    logic need_rank;
  } dp_sts_t;

  function automatic logic [POP_W-1:0] popcount32(input logic [WORD_BITS-1:0] x);
    logic [POP_W-1:0] n;
    n = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      n = n + POP_W'(x[i]);
    end
    return n;
  endfunction

endpackage

// ===== hw/rtl/bvr_ctrl.sv =====
// controller state machine for the bit vector rank block
module bvr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic [1:0]        action_i,
  input  bvr_pkg::dp_sts_t  sts_i,
  output bvr_pkg::ctl_cmd_t cmd_o,
  output logic              busy
);
  import bvr_pkg::*;

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.idx_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          if (action_e'(action_i) == ACT_BUILD) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_ACCESS;
          end
        end
      end
      ST_ACCESS: begin
        cmd_o.access = 1'b1;
        if (sts_i.need_rank) begin
          state_d = ST_RANK;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_RANK: begin
        cmd_o.rank_fin = 1'b1;
        state_d        = ST_IDLE;
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.idx_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cmd_o.build_fin = 1'b1;
        state_d         = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/bvr_datapath.sv =====
// word and prefix memories, popcount and result registers
module bvr_datapath #(
  parameter int unsigned VECTOR_BITS = 4096,
  parameter int unsigned NUM_WORDS   = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        action_i,
  input  logic [12:0]       position_i,
  input  logic              bit_value_i,
  input  bvr_pkg::ctl_cmd_t cmd_i,
  output bvr_pkg::dp_sts_t  sts_o,
  output logic [12:0]       count_o,
  output logic              bit_out_o,
  output logic [1:0]        status_o,
  output logic              done_o
);
  import bvr_pkg::*;

  localparam int unsigned AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  logic [WORD_BITS-1:0] word_mem [NUM_WORDS];
  logic [COUNT_W-1:0]   prefix_mem [NUM_WORDS];

  // operation registers
  action_e            act_q;
  logic [POS_W-1:0]   pos_q;
  logic               bv_q;
  logic [AW-1:0]      waddr_q;
  logic               built_q;

  // read data
  logic [WORD_BITS-1:0] word_q;
  logic [COUNT_W-1:0]   prefix_q;

  // sweep and build
  logic [AW-1:0]      idx_q;
  logic [AW-1:0]      scan_wr_q;
  logic               scan_vld_q;
  logic [COUNT_W-1:0] sum_q;
  logic [COUNT_W-1:0] sum_next;

  logic [POP_W-1:0]   pop_q;

  // results
  logic               done_q;
  logic [COUNT_W-1:0] count_q;
  logic               bit_q;
  status_e            status_q;

  // result selection
  logic               res_load;
  logic [COUNT_W-1:0] res_cnt;
  logic               res_bit;
  status_e            res_st;
  logic [COUNT_W-1:0] rank_sum;

  // address conversion, widening or narrowing the word index to AW bits
  logic [AW+WIDX_W-1:0] in_widx_ext;
  logic [AW+WIDX_W-1:0] in_pidx_ext;
  logic [WIDX_W-1:0]    in_widx;
  logic [AW-1:0]        in_waddr;
  logic [AW-1:0]        in_paddr;

  assign in_widx     = position_i[POS_W-1:WORD_SHIFT];
  assign in_widx_ext = {{AW{1'b0}}, in_widx};
  assign in_pidx_ext = {{AW{1'b0}}, in_widx - WIDX_W'(1)};
  assign in_waddr    = in_widx_ext[AW-1:0];
  assign in_paddr    = in_pidx_ext[AW-1:0];

  assign sts_o.idx_last = (idx_q == AW'(NUM_WORDS - 1));

  // range checks
  logic [WORD_SHIFT-1:0] sh;
  logic                  below_len;
  logic                  upto_len;
  logic                  widx_zero;

  assign sh        = pos_q[WORD_SHIFT-1:0];
  assign below_len = (32'(pos_q) <  32'(VECTOR_BITS));
  assign upto_len  = (32'(pos_q) <= 32'(VECTOR_BITS));
  assign widx_zero = (pos_q[POS_W-1:WORD_SHIFT] == '0);

  assign sts_o.need_rank = (act_q == ACT_RANK) && built_q && upto_len;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q   <= action_e'(action_i);
      pos_q   <= position_i;
      bv_q    <= bit_value_i;
      waddr_q <= in_waddr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      scan_vld_q <= 1'b0;
      built_q    <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      scan_vld_q <= cmd_i.scan_rd;
      done_q     <= res_load;
      if (cmd_i.clr_wr || cmd_i.scan_rd) begin
        idx_q <= sts_o.idx_last ? '0 : idx_q + AW'(1);
      end
      if (cmd_i.build_fin) begin
        built_q <= 1'b1;
      end
    end
  end

  // word memory: one read port, one write port
  logic                 word_re;
  logic [AW-1:0]        word_raddr;
  logic                 word_we;
  logic [AW-1:0]        word_waddr;
  logic [WORD_BITS-1:0] word_wdata;
  logic                 wb_en;
  logic [WORD_BITS-1:0] wb_data;
  logic [WORD_BITS-1:0] bit_sel;

  assign bit_sel    = WORD_BITS'(1) << sh;
  assign wb_data    = bv_q ? (word_q | bit_sel) : (word_q & ~bit_sel);
  assign wb_en      = cmd_i.access && (act_q == ACT_WRITE) && below_len;
  assign word_re    = cmd_i.load || cmd_i.scan_rd;
  assign word_raddr = cmd_i.scan_rd ? idx_q : in_waddr;
  assign word_we    = cmd_i.clr_wr || wb_en;
  assign word_waddr = cmd_i.clr_wr ? idx_q : waddr_q;
  assign word_wdata = cmd_i.clr_wr ? '0 : wb_data;

  always_ff @(posedge clk_i) begin
    if (word_we) begin
      word_mem[word_waddr] <= word_wdata;
    end
    if (word_re) begin
      word_q <= word_mem[word_raddr];
    end
  end

  // prefix memory: written by the build sweep, read at item load
  assign sum_next = sum_q + COUNT_W'(popcount32(word_q));

  always_ff @(posedge clk_i) begin
    if (scan_vld_q) begin
      prefix_mem[scan_wr_q] <= sum_next;
    end
    if (cmd_i.load) begin
      prefix_q <= prefix_mem[in_paddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_rd) begin
      scan_wr_q <= idx_q;
    end
    if (cmd_i.load) begin
      sum_q <= '0;
    end else if (scan_vld_q) begin
      sum_q <= sum_next;
    end
    if (cmd_i.access) begin
      pop_q <= popcount32(word_q & (bit_sel - WORD_BITS'(1)));
    end
  end

  assign rank_sum = (widx_zero ? '0 : prefix_q) + COUNT_W'(pop_q);
  assign res_load = (cmd_i.access && !sts_o.need_rank) || cmd_i.rank_fin || cmd_i.build_fin;

  always_comb begin
    res_cnt = '0;
    res_bit = 1'b0;
    res_st  = STAT_OK;
    if (cmd_i.rank_fin) begin
      res_cnt = bv_q ? rank_sum : (pos_q - rank_sum);
    end else if (cmd_i.access) begin
      unique case (act_q)
        ACT_WRITE: begin
          if (!below_len) begin
            res_st = STAT_RANGE;
          end
        end
        ACT_BUILD: begin
          res_st = STAT_OK;
        end
        ACT_RANK: begin
          if (!built_q) begin
            res_st = STAT_NOT_BUILT;
          end else if (!upto_len) begin
            res_st = STAT_RANGE;
          end
        end
        ACT_READ: begin
          if (!built_q) begin
            res_st = STAT_NOT_BUILT;
          end else if (!below_len) begin
            res_st = STAT_RANGE;
          end else begin
            res_bit = word_q[sh];
          end
        end
        default: begin
          res_st = STAT_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      count_q  <= res_cnt;
      bit_q    <= res_bit;
      status_q <= res_st;
    end
  end

  assign done_o    = done_q;
  assign count_o   = count_q;
  assign bit_out_o = bit_q;
  assign status_o  = status_q;

endmodule

// ===== hw/rtl/bit_vector_rank_core.sv =====
// bit vector rank block: top level joining controller and datapath
// order: item load, access, then the registered result; a rank adds a rank finish state before it
// a new transfer is taken only when the block is idle again, limited by the registered word read
// build sweeps the word memory one word a cycle, busy meanwhile
// after reset the word memory is cleared one word a cycle, busy high meanwhile
// results cannot be stalled; done_o marks each result for exactly one cycle
module bit_vector_rank_core #(
  parameter int unsigned VECTOR_BITS = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action_i,
  input  logic [12:0] position_i,
  input  logic        bit_value_i,
  output logic        done_o,
  output logic [12:0] count_o,
  output logic        bit_out_o,
  output logic [1:0]  status_o
);
  import bvr_pkg::*;

  // words of 32 bits, last one padded with zeros
  localparam int unsigned NUM_WORDS = (VECTOR_BITS + WORD_BITS - 1) / WORD_BITS;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  // sequencing: clear sweep, item load, access, rank finish, build sweep
  bvr_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .action_i (action_i),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  // memories, popcount and the registered result
  bvr_datapath #(
    .VECTOR_BITS (VECTOR_BITS),
    .NUM_WORDS   (NUM_WORDS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .action_i    (action_i),
    .position_i  (position_i),
    .bit_value_i (bit_value_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .count_o     (count_o),
    .bit_out_o   (bit_out_o),
    .status_o    (status_o),
    .done_o      (done_o)
  );

`ifndef NO_ASSERTIONS
  // an accepted transfer always makes the block busy in the following cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("block not busy after transfer");

  // a result is only shown once the block is free again
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  // a result is always preceded by work, with the block busy just before it
  a_done_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result without preceding work");

  // failed status carries zero payload
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != STAT_OK) |-> (count_o == '0 && bit_out_o == 1'b0))
    else $error("non-zero payload with failed status");
`endif

endmodule
